FILE: src/mwps_pkg.sv
// ----------------------------------------------------------------------------
// mwps_pkg : shared definitions for the multi-waveform phase shaper
// Waveform codes, fixed port widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package mwps_pkg;

  // Fixed field widths
  localparam int PHASE_BITS = 24;
  localparam int WAVE_BITS  = 3;

  // Parameter defaults
  localparam int DEF_PHASE_FRAC_BITS = 16;
  localparam int DEF_SAMPLE_BITS     = 16;

  // Waveform select codes
  localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd0;
  localparam logic [WAVE_BITS-1:0] WAVE_SAWTOOTH = 3'd1;
  localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd2;
  localparam logic [WAVE_BITS-1:0] WAVE_TRAPEZOID = 3'd3;
  localparam logic [WAVE_BITS-1:0] WAVE_PARABOLIC = 3'd4;
  localparam logic [WAVE_BITS-1:0] WAVE_ROOT     = 3'd5;

endpackage

`default_nettype wire

FILE: src/mwps_fold.sv
// ----------------------------------------------------------------------------
// mwps_fold : phase folding stage
// Takes |phase|, keeps the fraction p of a turn and forms u = |2p - 1|.
// ----------------------------------------------------------------------------
`default_nettype none

module mwps_fold #(
  parameter int PHASE_FRAC_BITS = mwps_pkg::DEF_PHASE_FRAC_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mwps_pkg::PHASE_BITS-1:0] phase,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [PHASE_FRAC_BITS-1:0]           p,
  output logic [PHASE_FRAC_BITS:0]             u
);
  import mwps_pkg::*;

  localparam int F = PHASE_FRAC_BITS;
  localparam logic signed [F+1:0] ONE = (F+2)'(1) << F;

  logic                   en;
  logic [PHASE_BITS-1:0]  mag;
  logic [F-1:0]           p_next;
  logic signed [F+1:0]    d;
  logic [F:0]             u_next;

  // magnitude; the most negative value folds to 2^23, a whole turn count
  always_comb begin
    mag    = phase[PHASE_BITS-1] ? (~phase + PHASE_BITS'(1)) : phase;
    p_next = mag[F-1:0];
    d      = $signed({1'b0, p_next, 1'b0}) - ONE;
    u_next = d[F+1] ? (F+1)'(-d) : (F+1)'(d);
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= p_next;
      u <= u_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/mwps_shape.sv
// ----------------------------------------------------------------------------
// mwps_shape : waveform shaping stages
// Stage 1 forms the linear numerators, square product and root operand.
// Stage 2 rounds to the sample grid and selects the shaped value.
// ----------------------------------------------------------------------------
`default_nettype none

module mwps_shape #(
  parameter int PHASE_FRAC_BITS = mwps_pkg::DEF_PHASE_FRAC_BITS,
  parameter int SAMPLE_BITS     = mwps_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [mwps_pkg::WAVE_BITS-1:0] waveform,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [PHASE_FRAC_BITS-1:0]     p,
  input  wire logic [PHASE_FRAC_BITS:0]       u,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_BITS:0]         shaped,
  output logic [2*SAMPLE_BITS+3:0]            y
);
  import mwps_pkg::*;

  localparam int F  = PHASE_FRAC_BITS;
  localparam int S  = SAMPLE_BITS;
  localparam int YP = 2*S + 4;

  // selection kinds inside this block
  localparam logic [1:0] KIND_LIN   = 2'd0;
  localparam logic [1:0] KIND_CONST = 2'd1;
  localparam logic [1:0] KIND_PAR   = 2'd2;

  // phase thresholds
  localparam logic [F-1:0] P_HALF = F'(1) << (F-1);
  localparam logic [F-1:0] P_3_8  = F'(3) << (F-3);
  localparam logic [F-1:0] P_7_8  = F'(7) << (F-3);

  // one turn in the wide numerator width
  localparam logic signed [F+5:0] ONE_W = (F+6)'(1) << F;

  // sample constants
  localparam logic signed [S:0] SQ_POS = (S+1)'(1) << (S-2);
  localparam logic signed [S:0] SQ_NEG = -SQ_POS;
  localparam logic signed [S:0] S_HI   = ((S+1)'(1) << (S-1)) - (S+1)'(1);
  localparam logic signed [S:0] S_LO   = -((S+1)'(1) << (S-1));

  // root operand: u scaled to 2S+2 fractional bits
  localparam int E   = 2*S + 2 - F;
  localparam int YML = (E > 0) ? E : 0;
  localparam int YKR = (E < 0) ? -E : 0;
  localparam int YXW = F + 1 + YML;

  // linear rounding, numerator has F fractional bits
  localparam int LS  = F - (S-1);
  localparam int LML = (LS < 0) ? -LS : 0;
  localparam int LKR = (LS > 0) ? LS : 0;
  localparam int LW  = F + 3 + LML;
  localparam logic signed [LW-1:0] LRND =
    (LKR > 0) ? (LW'(1) << ((LKR > 0) ? LKR - 1 : 0)) : LW'(0);

  // parabolic rounding, numerator has 2F fractional bits
  localparam int PS  = 2*F - (S-1);
  localparam int PML = (PS < 0) ? -PS : 0;
  localparam int PKR = (PS > 0) ? PS : 0;
  localparam int PNW = 2*F + 3;
  localparam int PW  = PNW + 1 + PML;
  localparam logic signed [PW-1:0] PRND =
    (PKR > 0) ? (PW'(1) << ((PKR > 0) ? PKR - 1 : 0)) : PW'(0);
  localparam logic signed [PNW-1:0] ONE_SQ = PNW'(1) << (2*F);

  logic en_b, en_c, v_b;

  // stage 1 registers
  logic [1:0]          kind_b;
  logic signed [F+1:0] lin_b;
  logic signed [S:0]   const_b;
  logic [2*F:0]        uu_b;
  logic [YP-1:0]       y_b;

  // stage 1 logic
  logic signed [F+5:0] pw, uw, tri_n, saw_n, fall_n, rise_n, lin_w;
  logic [1:0]          kind_next;
  logic signed [S:0]   const_next;
  logic [2*F+1:0]      uu_full;
  logic [YXW-1:0]      y_ext;

  always_comb begin
    pw     = $signed({6'b0, p});
    uw     = $signed({5'b0, u});
    tri_n  = (uw <<< 1) - ONE_W;
    saw_n  = ONE_W - (pw <<< 1);
    fall_n = (ONE_W <<< 3) - ONE_W - (pw <<< 4);
    rise_n = (pw <<< 4) - ((ONE_W <<< 4) - ONE_W);
    kind_next  = KIND_CONST;
    const_next = '0;
    lin_w      = tri_n;
    case (waveform)
      WAVE_TRIANGLE: begin
        kind_next = KIND_LIN;
      end
      WAVE_SAWTOOTH: begin
        kind_next = KIND_LIN;
        lin_w     = saw_n;
      end
      WAVE_SQUARE: begin
        const_next = (p < P_HALF) ? SQ_POS : SQ_NEG;
      end
      WAVE_TRAPEZOID: begin
        if (p >= P_3_8 && p <= P_HALF) begin
          kind_next = KIND_LIN;
          lin_w     = fall_n;
        end else if (p >= P_7_8) begin
          kind_next = KIND_LIN;
          lin_w     = rise_n;
        end else begin
          const_next = (p < P_HALF) ? S_HI : S_LO;
        end
      end
      WAVE_PARABOLIC: begin
        kind_next = KIND_PAR;
      end
      default: begin
        // root curve is finished downstream; unused codes give zero
        kind_next  = KIND_CONST;
        const_next = '0;
      end
    endcase
    uu_full = u * u;
    y_ext   = YXW'(u) << YML;
  end

  assign en_c     = !out_valid || out_ready;
  assign en_b     = !v_b || en_c;
  assign in_ready = en_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_b) begin
        v_b <= in_valid;
      end
      if (en_c) begin
        out_valid <= v_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      kind_b  <= kind_next;
      lin_b   <= lin_w[F+1:0];
      const_b <= const_next;
      uu_b    <= uu_full[2*F:0];
      y_b     <= YP'(y_ext >> YKR);
    end
  end

  // stage 2 logic: round half up onto the sample grid
  logic signed [LW-1:0]  lin_ext, lin_sum;
  logic signed [PNW-1:0] par_n;
  logic signed [PW-1:0]  par_ext, par_sum;
  logic signed [S:0]     shaped_next;

  always_comb begin
    lin_ext = LW'(lin_b) <<< LML;
    lin_sum = (lin_ext + LRND) >>> LKR;
    par_n   = $signed({1'b0, uu_b, 1'b0}) - ONE_SQ;
    par_ext = PW'(par_n) <<< PML;
    par_sum = (par_ext + PRND) >>> PKR;
    case (kind_b)
      KIND_LIN:   shaped_next = lin_sum[S:0];
      KIND_PAR:   shaped_next = par_sum[S:0];
      KIND_CONST: shaped_next = const_b;
      default:    shaped_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      shaped <= shaped_next;
      y      <= y_b;
    end
  end

endmodule

`default_nettype wire

FILE: src/mwps_isqrt.sv
// ----------------------------------------------------------------------------
// mwps_isqrt : pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage, with a
// side word carried along so that order is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module mwps_isqrt #(
  parameter int SAMPLE_BITS = mwps_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2*SAMPLE_BITS+3:0] y,
  input  wire logic [SAMPLE_BITS:0]     side_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [SAMPLE_BITS+1:0]        q,
  output logic [SAMPLE_BITS:0]          side_out
);
  import mwps_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int RB = S + 2;
  localparam int YP = 2 * RB;
  localparam int RW = RB + 3;

  logic [RB:1]     v;
  logic [RB+1:1]   en;
  logic [RW-1:0]   rem_a  [1:RB];
  logic [RB-1:0]   root_a [1:RB];
  logic [YP-1:0]   yr_a   [1:RB];
  logic [S:0]      side_a [1:RB];

  assign en[RB+1]  = out_ready;
  assign in_ready  = en[1];
  assign out_valid = v[RB];
  assign q         = root_a[RB];
  assign side_out  = side_a[RB];

  for (genvar i = 1; i <= RB; i++) begin : g_stage
    logic          v_p;
    logic [RW-1:0] rem_p, rem_s, trial;
    logic [RB-1:0] root_p;
    logic [YP-1:0] yr_p;
    logic [S:0]    side_p;

    // source of this stage
    if (i == 1) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign yr_p   = y;
      assign side_p = side_in;
    end else begin : g_next
      assign v_p    = v[i-1];
      assign rem_p  = rem_a[i-1];
      assign root_p = root_a[i-1];
      assign yr_p   = yr_a[i-1];
      assign side_p = side_a[i-1];
    end

    // bring down two operand bits and try the next root bit
    always_comb begin
      rem_s = {rem_p[RW-3:0], yr_p[YP-1 -: 2]};
      trial = RW'({root_p, 2'b01});
    end

    assign en[i] = !v[i] || en[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        if (rem_s >= trial) begin
          rem_a[i]  <= rem_s - trial;
          root_a[i] <= {root_p[RB-2:0], 1'b1};
        end else begin
          rem_a[i]  <= rem_s;
          root_a[i] <= {root_p[RB-2:0], 1'b0};
        end
        yr_a[i]   <= yr_p << 2;
        side_a[i] <= side_p;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/multi_waveform_phase_shaper.sv
// ----------------------------------------------------------------------------
// multi_waveform_phase_shaper : phase to amplitude converter
// Turns a signed phase in turns into one sample of a selectable waveform.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one phase word per transfer (24-bit signed turns with
//   PHASE_FRAC_BITS fractional bits); m_axis returns one signed
//   Q1.(SAMPLE_BITS-1) sample word per phase word, in order.
//   cfg_we/cfg_wdata write the waveform select: 0 triangle, 1 sawtooth,
//   2 square, 3 trapezoid square, 4 parabolic, 5 root curve; 6 and 7
//   give zero. Write it only while no words are in flight.
//   The pipe holds one fold stage, two shaping stages, SAMPLE_BITS + 2
//   square root stages (one root bit each) and the output register. It
//   takes one word per cycle while m_axis does not stall.
//   Each stage holds its own valid bit, so bubbles close up and s_axis keeps
//   accepting while a result waits on m_axis, until the pipe is full.
//   When the receiver stalls, the output word holds and the pipe fills; no
//   word is lost or repeated. rst (synchronous) empties the pipe and
//   selects the triangle.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_waveform_phase_shaper #(
  parameter int PHASE_FRAC_BITS = mwps_pkg::DEF_PHASE_FRAC_BITS,
  parameter int SAMPLE_BITS     = mwps_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // waveform select register
  input  wire logic                             cfg_we,
  input  wire logic [mwps_pkg::WAVE_BITS-1:0]   cfg_wdata,
  // phase in
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [mwps_pkg::PHASE_BITS-1:0]  s_axis_tdata,  // [23:0] phase
  // sample out
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata   // sample, then 0
);
  import mwps_pkg::*;

  localparam int F     = PHASE_FRAC_BITS;
  localparam int S     = SAMPLE_BITS;
  localparam int OUT_W = ((S+7)/8)*8;

  localparam logic signed [S+1:0] HALF_W = (S+2)'(1) << (S-1);
  localparam logic signed [S+1:0] HI_W   = HALF_W - (S+2)'(1);
  localparam logic signed [S+1:0] LO_W   = -HALF_W;
  localparam logic [S-1:0]        SQ_POS = S'(1) << (S-2);
  localparam logic [S-1:0]        SQ_NEG = -SQ_POS;

  // waveform select register
  logic [WAVE_BITS-1:0] waveform;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform <= WAVE_TRIANGLE;
    end else if (cfg_we) begin
      waveform <= cfg_wdata;
    end
  end

  // fold
  logic         fold_valid, fold_ready;
  logic [F-1:0] fold_p;
  logic [F:0]   fold_u;

  mwps_fold #(
    .PHASE_FRAC_BITS(F)
  ) u_fold (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .phase    (s_axis_tdata),
    .out_valid(fold_valid),
    .out_ready(fold_ready),
    .p        (fold_p),
    .u        (fold_u)
  );

  // shape
  logic              shp_valid, shp_ready;
  logic signed [S:0] shp_value;
  logic [2*S+3:0]    shp_y;

  mwps_shape #(
    .PHASE_FRAC_BITS(F),
    .SAMPLE_BITS    (S)
  ) u_shape (
    .clk      (clk),
    .rst      (rst),
    .waveform (waveform),
    .in_valid (fold_valid),
    .in_ready (fold_ready),
    .p        (fold_p),
    .u        (fold_u),
    .out_valid(shp_valid),
    .out_ready(shp_ready),
    .shaped   (shp_value),
    .y        (shp_y)
  );

  // square root
  logic         rt_valid, rt_ready;
  logic [S+1:0] rt_q;
  logic [S:0]   rt_side;

  mwps_isqrt #(
    .SAMPLE_BITS(S)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (shp_valid),
    .in_ready (shp_ready),
    .y        (shp_y),
    .side_in  (shp_value),
    .out_valid(rt_valid),
    .out_ready(rt_ready),
    .q        (rt_q),
    .side_out (rt_side)
  );

  // root curve finish, select and saturate
  logic [S+1:0]        q_inc;
  logic [S:0]          r;
  logic signed [S+1:0] root_s, pick;
  logic [S-1:0]        sample_next;
  logic [S-1:0]        sample;

  always_comb begin
    q_inc  = rt_q + (S+2)'(1);
    r      = q_inc[S+1:1];
    root_s = $signed({1'b0, r}) - HALF_W;
    pick   = (waveform == WAVE_ROOT) ? root_s : (S+2)'($signed(rt_side));
    if (pick > HI_W) begin
      sample_next = HI_W[S-1:0];
    end else if (pick < LO_W) begin
      sample_next = LO_W[S-1:0];
    end else begin
      sample_next = pick[S-1:0];
    end
  end

  // output register
  assign rt_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (rt_ready) begin
      m_axis_tvalid <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rt_ready) begin
      sample <= sample_next;
    end
  end

  assign m_axis_tdata = OUT_W'(sample);

`ifndef SYNTHESIS
  // an empty output register means every stage can advance
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // square wave only ever yields plus or minus one half
  a_square_levels: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && waveform == WAVE_SQUARE) |-> (sample == SQ_POS || sample == SQ_NEG))
    else $error("square wave level out of set");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
